### sv/tbu_pkg.sv
// Types and constants shared by the Thumb branch unit modules.
// No dependencies.
package tbu_pkg;

  typedef enum logic [1:0] {
    MODE_BCOND = 2'd0,
    MODE_B     = 2'd1,
    MODE_BLX   = 2'd2,
    MODE_BX    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDEF = 2'd1,
    FAULT_ALIGN = 2'd2,
    FAULT_PC    = 2'd3
  } fault_t;

  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] REG_PC  = 4'd15;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] opcode_word;
    logic [31:0] pc_value;
    logic [3:0]  nzcv_flags;
    logic [31:0] reg_operand;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        link_write;
    logic [31:0] link_value;
    logic        to_arm;
    fault_t      fault;
  } result_t;

endpackage

### sv/thumb16_branch_unit.sv
// Thumb branch unit: executes one 16-bit Thumb branch (B cond, B, BLX reg, BX reg)
// per beat and returns one result beat. A beat is captured in an input register,
// resolved by combinational condition test and target add, and held in an output
// register; one beat can enter every cycle unless out_tready holds back the output
// register. No state is kept between beats. Depends on tbu_pkg and tbu_exec.
module thumb16_branch_unit
  import tbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic [87:0] in_tdata,   // [15:0] opcode_word, [47:16] pc_value,
                                  // [51:48] nzcv_flags, [83:52] reg_operand, [87:84] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] next_pc, [32] link_write, [64:33] link_value,
                                  // [65] to_arm, [67:66] fault, [71:68] zero
);

  item_t   item_r, item_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    s1_adv;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    item_nxt.mode        = mode_t'(in_tuser);
    item_nxt.opcode_word = in_tdata[15:0];
    item_nxt.pc_value    = in_tdata[47:16];
    item_nxt.nzcv_flags  = in_tdata[51:48];
    item_nxt.reg_operand = in_tdata[83:52];
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  tbu_exec u_exec (
    .item (item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.fault, res_r.to_arm, res_r.link_value,
                       res_r.link_write, res_r.next_pc};

`ifndef SYNTH
  a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.fault != FAULT_NONE
      |-> res_r.next_pc == 32'd0 && !res_r.link_write && !res_r.to_arm)
    else $error("faulted result carries a branch");

  a_link_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.link_write |-> res_r.link_value[0])
    else $error("link value not marked Thumb");

  a_arm_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.to_arm |-> res_r.next_pc[1:0] == 2'b00)
    else $error("ARM target not word aligned");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_tvalid)
    else $error("resolved beat lost");
`endif

endmodule

### sv/tbu_exec.sv
// Branch execute logic: condition test, target add, interworking checks.
// Depends on tbu_pkg.
module tbu_exec
  import tbu_pkg::*;
(
  input  item_t   item,
  output result_t res
);

  function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
    logic n, z, c, v, r;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    unique case (cond)
      4'd0:    r = z;
      4'd1:    r = !z;
      4'd2:    r = c;
      4'd3:    r = !c;
      4'd4:    r = n;
      4'd5:    r = !n;
      4'd6:    r = v;
      4'd7:    r = !v;
      4'd8:    r = c && !z;
      4'd9:    r = !c || z;
      4'd10:   r = n == v;
      4'd11:   r = n != v;
      4'd12:   r = !z && (n == v);
      4'd13:   r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  logic [3:0]  cond;
  logic [3:0]  reg_idx;
  logic [31:0] off;
  logic [31:0] pc_plus2;
  logic [31:0] target;
  logic [31:0] rv;

  assign cond     = item.opcode_word[11:8];
  assign reg_idx  = item.opcode_word[6:3];
  assign rv       = item.reg_operand;
  assign pc_plus2 = item.pc_value + 32'd2;
  assign off      = (item.mode == MODE_BCOND)
                  ? {{23{item.opcode_word[7]}}, item.opcode_word[7:0], 1'b0}
                  : {{20{item.opcode_word[10]}}, item.opcode_word[10:0], 1'b0};
  assign target   = item.pc_value + 32'd4 + off;

  always_comb begin
    res.next_pc    = '0;
    res.link_write = 1'b0;
    res.link_value = '0;
    res.to_arm     = 1'b0;
    res.fault      = FAULT_NONE;
    unique case (item.mode)
      MODE_BCOND: begin
        if (cond == COND_AL) begin
          res.fault = FAULT_UNDEF;
        end else if (!cond_holds(cond, item.nzcv_flags)) begin
          res.next_pc = pc_plus2;
        end else begin
          res.next_pc = target;
        end
      end
      MODE_B: begin
        res.next_pc = target;
      end
      default: begin
        if (item.mode == MODE_BLX && reg_idx == REG_PC) begin
          res.fault = FAULT_PC;
        end else if (rv[0]) begin
          res.next_pc = {rv[31:1], 1'b0};
        end else if (rv[1]) begin
          res.fault = FAULT_ALIGN;
        end else begin
          res.next_pc = rv;
          res.to_arm  = 1'b1;
        end
        if (item.mode == MODE_BLX && res.fault == FAULT_NONE) begin
          res.link_write = 1'b1;
          res.link_value = {pc_plus2[31:1], 1'b1};
        end
      end
    endcase
  end

endmodule
